// ===== rtl/shabs_pkg.sv =====
package shabs_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned BLOCK_BITS  = BLOCK_BYTES * 8;
  localparam int unsigned POS_W       = $clog2(BLOCK_BYTES);
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned RND_W       = $clog2(ROUNDS);
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [7:0]       PAD_BYTE = 8'h80;
  localparam logic [POS_W-1:0] LEN_POS  = POS_W'(56);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [0:7][WORD_W-1:0] hash_t;

  localparam hash_t H_INIT = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // One classified transaction handed from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ZERO,
    ST_LEN,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } st_e;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic word_t bsig0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t ch(word_t e, word_t f, word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t maj(word_t a, word_t b, word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

  function automatic word_t round_k(logic [RND_W-1:0] idx);
    word_t k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;
      6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;
      6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;
      6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;
      6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;
      6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;
      6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;
      6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;
      6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;
      6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;
      6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;
      6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;
      6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;
      6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;
      6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;
      6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;
      6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;
      6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;
      6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;
      6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;
      6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;
      6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/sha256_byte_stream_hash.sv =====
// Path: a byte passes the hold stage and then the queue before the back end shifts it into
//   the block register; the 64th byte of a block starts the 64 rounds and then the fold.
// End of message: pad byte, zero fill and the eight length bytes, with the 64 rounds and
//   the fold for each block they fill (a second block if the pad spills past the length
//   field); then the 8 digest words go out one at a time as the receiver takes them.
// The round logic is shared, so no bytes leave the queue while a block's rounds run.
// Reset: asynchronous, active low; queue empty, chaining state loaded with the initial hash.
module sha256_byte_stream_hash import shabs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  // Front stage -> queue: classified transactions, empty ones dropped.
  logic f_valid, f_ready;
  cmd_t f_cmd;

  // Queue -> back end: transactions waiting for the compression engine.
  logic q_valid, q_ready;
  cmd_t q_cmd;

  // Accept and classify; hold one transaction while the queue is full.
  shabs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .byte_valid_i    (byte_valid_i),
    .end_of_message_i(end_of_message_i),
    .push_valid_o    (f_valid),
    .push_ready_i    (f_ready),
    .push_cmd_o      (f_cmd)
  );

  // Decouple the front from the compression engine so input keeps flowing, until the queue
  // fills, while rounds run or digest words wait.
  shabs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_ready_o(f_ready),
    .push_cmd_i  (f_cmd),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_cmd_o   (q_cmd)
  );

  // Gather bytes, pad, run the rounds and emit the digest words.
  shabs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (q_valid),
    .pop_ready_o  (q_ready),
    .pop_cmd_i    (q_cmd),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digest_word_o(digest_word_o),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o)
  );

endmodule

// ===== rtl/shabs_front.sv =====
module shabs_front import shabs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       byte_valid_i,
  input  logic       end_of_message_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output cmd_t       push_cmd_o
);

  logic hold_valid_q, hold_valid_d;
  cmd_t hold_q, hold_d;
  logic accept;

  assign in_ready_o   = !hold_valid_q || push_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = hold_valid_q;
  assign push_cmd_o   = hold_q;

  // Drop transactions that carry neither a byte nor an end mark.
  always_comb begin
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    if (accept) begin
      hold_valid_d    = byte_valid_i || end_of_message_i;
      hold_d.data     = data_byte_i;
      hold_d.has_byte = byte_valid_i;
      hold_d.eom      = end_of_message_i;
    end else if (push_ready_i) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

endmodule

// ===== rtl/shabs_fifo.sv =====
module shabs_fifo import shabs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + QCNT_W'(1);
      else if (!do_push && do_pop) cnt_q <= cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

// ===== rtl/shabs_back.sv =====
module shabs_back import shabs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  cmd_t        pop_cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  st_e                  state_q, state_d, after_q, after_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [63:0]          count_q, count_d;
  logic [RND_W-1:0]     rnd_q, rnd_d;
  logic [2:0]           idx_q, idx_d;
  hash_t                h_q, h_d, v_q, v_d;
  logic [63:0]          len_q, len_d;
  logic [BLOCK_BITS-1:0] block_q, block_d;

  logic       shift_en, start_rnd, blk_last;
  logic [7:0] shift_byte;
  word_t      w0, w1, w9, w14, w_new, t1, t2;

  assign blk_last = &pos_q;

  // Message schedule window: word 0 sits at the top of the block register.
  assign w0    = block_q[BLOCK_BITS-1 -: WORD_W];
  assign w1    = block_q[BLOCK_BITS-1-WORD_W -: WORD_W];
  assign w9    = block_q[BLOCK_BITS-1-9*WORD_W -: WORD_W];
  assign w14   = block_q[BLOCK_BITS-1-14*WORD_W -: WORD_W];
  assign w_new = ssig1(w14) + w9 + ssig0(w1) + w0;

  assign t1 = v_q[7] + bsig1(v_q[4]) + ch(v_q[4], v_q[5], v_q[6]) + round_k(rnd_q) + w0;
  assign t2 = bsig0(v_q[0]) + maj(v_q[0], v_q[1], v_q[2]);

  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = h_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = &idx_q;

  always_comb begin
    state_d     = state_q;
    after_d     = after_q;
    pos_d       = pos_q;
    count_d     = count_q;
    rnd_d       = rnd_q;
    idx_d       = idx_q;
    h_d         = h_q;
    v_d         = v_q;
    len_d       = len_q;
    block_d     = block_q;
    shift_en    = 1'b0;
    shift_byte  = '0;
    start_rnd   = 1'b0;
    pop_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          pop_ready_o = 1'b1;
          if (pop_cmd_i.has_byte) begin
            shift_en   = 1'b1;
            shift_byte = pop_cmd_i.data;
            count_d    = count_q + 64'd1;
          end
          if (pop_cmd_i.has_byte && blk_last) begin
            state_d   = ST_ROUND;
            start_rnd = 1'b1;
            after_d   = pop_cmd_i.eom ? ST_PAD : ST_IDLE;
          end else if (pop_cmd_i.eom) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        shift_en   = 1'b1;
        shift_byte = PAD_BYTE;
        len_d      = {count_q[60:0], 3'b000};
        if (blk_last) begin
          state_d   = ST_ROUND;
          start_rnd = 1'b1;
          after_d   = ST_ZERO;
        end else begin
          state_d = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (pos_q == LEN_POS) begin
          state_d = ST_LEN;
        end else begin
          shift_en = 1'b1;
          if (blk_last) begin
            state_d   = ST_ROUND;
            start_rnd = 1'b1;
            after_d   = ST_ZERO;
          end
        end
      end
      ST_LEN: begin
        shift_en   = 1'b1;
        shift_byte = len_q[63:56];
        len_d      = {len_q[55:0], 8'h00};
        if (blk_last) begin
          state_d   = ST_ROUND;
          start_rnd = 1'b1;
          after_d   = ST_OUT;
        end
      end
      ST_ROUND: begin
        v_d     = {t1 + t2, v_q[0], v_q[1], v_q[2], v_q[3] + t1, v_q[4], v_q[5], v_q[6]};
        block_d = {block_q[BLOCK_BITS-WORD_W-1:0], w_new};
        rnd_d   = rnd_q + RND_W'(1);
        if (&rnd_q) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        state_d = after_q;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (&idx_q) begin
            h_d     = H_INIT;
            count_d = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (shift_en) begin
      block_d = {block_q[BLOCK_BITS-9:0], shift_byte};
      pos_d   = pos_q + POS_W'(1);
    end
    if (start_rnd) begin
      v_d   = h_q;
      rnd_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      after_q <= ST_IDLE;
      pos_q   <= '0;
      count_q <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      h_q     <= H_INIT;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      pos_q   <= pos_d;
      count_q <= count_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      h_q     <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    len_q   <= len_d;
    block_q <= block_d;
  end

endmodule

// ===== rtl/shabs_checker.sv =====
module shabs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  data_byte_i,
  input logic        byte_valid_i,
  input logic        end_of_message_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);

  // Hold a stalled digest word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(digest_word_o)
                                     && $stable(word_index_o))
    else $error("digest word changed while stalled");

  // Advance the word index by one inside a digest.
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_word_o |=>
      out_valid_o && (word_index_o == $past(word_index_o) + 3'd1))
    else $error("digest words not consecutive");

  // Drop valid after the final word.
  a_last_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_word_o |=> !out_valid_o)
    else $error("output still valid after last word");

  // Start every digest at word zero.
  a_first_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (word_index_o == 3'd0) && !last_word_o)
    else $error("digest did not start at word zero");

endmodule

bind sha256_byte_stream_hash shabs_checker u_shabs_checker (.*);

// ===== test/sha256_digest_checker.sv =====
module sha256_digest_checker import shabs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        last_word_i,
  output int          fail_count_o,
  output int          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam word_t SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    word_t      word;
    logic [2:0] slot;
    logic       is_last;
  } digest_entry_t;

  hash_t         chain_h = H_INIT;
  logic [7:0]    msg_buf [BLOCK_BYTES] = '{default: '0};
  logic [63:0]   msg_len = '0;
  digest_entry_t digest_words_due [$];
  int            fails = 0;

  assign fail_count_o = fails;

  function automatic word_t ror(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Run the 64 rounds over msg_buf and fold the result into chain_h.
  function automatic void fold_block();
    word_t w [64];
    word_t a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    end
    {a, b, c, d, e, f, g, h} = chain_h;
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
         + SHA_K[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g;
      g = f;
      f = e;
      e = d + t1;
      d = c;
      c = b;
      b = a;
      a = t1 + t2;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
    chain_h[5] += f;
    chain_h[6] += g;
    chain_h[7] += h;
  endfunction

  // Absorb one input transaction; on end of message pad, finish and queue the digest.
  function automatic void absorb_txn(logic [7:0] d, logic bv, logic eom);
    int unsigned   pos;
    logic [63:0]   bit_len;
    digest_entry_t ent;
    if (bv) begin
      msg_buf[msg_len[5:0]] = d;
      msg_len = msg_len + 64'd1;
      if (msg_len[5:0] == 6'd0) fold_block();
    end
    if (eom) begin
      pos = msg_len[5:0];
      msg_buf[pos] = PAD_BYTE;
      pos = pos + 1;
      if (pos > LEN_POS) begin
        while (pos < BLOCK_BYTES) begin
          msg_buf[pos] = '0;
          pos = pos + 1;
        end
        fold_block();
        pos = 0;
      end
      while (pos < LEN_POS) begin
        msg_buf[pos] = '0;
        pos = pos + 1;
      end
      bit_len = msg_len << 3;
      for (int j = 0; j < 8; j++) msg_buf[LEN_POS + j] = bit_len[63 - 8*j -: 8];
      fold_block();
      for (int j = 0; j < 8; j++) begin
        ent.word    = chain_h[j];
        ent.slot    = 3'(j);
        ent.is_last = (j == 7);
        digest_words_due.push_back(ent);
      end
      chain_h = H_INIT;
      msg_len = '0;
    end
  endfunction

  always @(posedge clk_i) begin
    digest_entry_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (digest_words_due.size() == 0) begin
          $error("unexpected digest word %08h at index %0d", digest_word_i, word_index_i);
          fails++;
        end else begin
          want = digest_words_due.pop_front();
          if (digest_word_i !== want.word) begin
            $error("digest_word: expected %08h, got %08h", want.word, digest_word_i);
            fails++;
          end
          if (word_index_i !== want.slot) begin
            $error("word_index: expected %0d, got %0d", want.slot, word_index_i);
            fails++;
          end
          if (last_word_i !== want.is_last) begin
            $error("last_word: expected %0b, got %0b", want.is_last, last_word_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) absorb_txn(data_byte_i, byte_valid_i, end_of_message_i);
      pending_o = digest_words_due.size();
    end
  end

endmodule

// ===== test/tb.sv =====
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Generous bound: a few hundred items, a couple dozen messages, heavy stalls.
  localparam int CYCLE_LIMIT = 1000000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        byte_valid_i;
  logic        end_of_message_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  int fail_count;
  int words_pending;
  int cycle_count   = 0;
  int items_sent    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Message lengths that sit on the padding boundaries: the pad and length
  // fit, just fit, or spill into a second block; full blocks exactly.
  int edge_lengths [10] = '{54, 55, 56, 57, 63, 64, 65, 119, 120, 128};

  sha256_byte_stream_hash u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .byte_valid_i     (byte_valid_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .digest_word_o    (digest_word_o),
    .word_index_o     (word_index_o),
    .last_word_o      (last_word_o)
  );

  sha256_digest_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .byte_valid_i     (byte_valid_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .digest_word_i    (digest_word_o),
    .word_index_i     (word_index_o),
    .last_word_i      (last_word_o),
    .fail_count_o     (fail_count),
    .pending_o        (words_pending)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Watchdog: give up if the run hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: stall at random, one decision per cycle, changed on the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Drive one transaction. Call on a falling edge; returns on the falling edge
  // after the transaction is accepted with valid still high, so back-to-back
  // transactions keep valid up without a gap.
  task automatic drive_txn(input logic [7:0] d, input logic bv, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    data_byte_i      = d;
    byte_valid_i     = bv;
    end_of_message_i = eom;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Send a message of random bytes. Either the last byte carries the end flag,
  // or a separate end transaction follows with junk on the data lines. Scatter
  // empty transactions in between; the block must ignore them.
  task automatic send_message(input int len, input bit end_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) drive_txn(8'($urandom), 1'b0, 1'b0);
      drive_txn(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0) drive_txn(8'($urandom), 1'b0, 1'b1);
  endtask

  // Mostly short messages, some on the padding boundaries, some medium.
  task automatic send_random_message();
    int pick;
    int len;
    pick = $urandom_range(99);
    if (pick < 60)      len = $urandom_range(0, 10);
    else if (pick < 80) len = edge_lengths[$urandom_range(9)];
    else                len = $urandom_range(11, 70);
    send_message(len, $urandom_range(99) < 40);
  endtask

  // Hold off the sender until every digest word due has come out.
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (words_pending != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    data_byte_i      = '0;
    byte_valid_i     = 1'b0;
    end_of_message_i = 1'b0;
    out_ready_i      = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty transaction, empty message, a short text, byte extremes,
    // end on its own and end riding on the last byte.
    drive_txn(8'hA5, 1'b0, 1'b0);
    drive_txn(8'h00, 1'b0, 1'b1);
    drive_txn(8'h61, 1'b1, 1'b0);
    drive_txn(8'h62, 1'b1, 1'b0);
    drive_txn(8'h63, 1'b1, 1'b1);
    drive_txn(8'h00, 1'b1, 1'b0);
    drive_txn(8'hFF, 1'b0, 1'b1);
    drive_txn(8'hFF, 1'b1, 1'b1);
    drive_txn(8'h5A, 1'b0, 1'b0);
    drive_txn(8'hFF, 1'b1, 1'b0);
    drive_txn(8'h00, 1'b1, 1'b0);
    drive_txn(8'h3C, 1'b0, 1'b1);
    drive_txn(8'hC3, 1'b0, 1'b1);
    wait_drained();

    // Random: sender mostly busy and receiver mostly stalled.
    send_idle_pct = 25;
    recv_idle_pct = 86;
    while (items_sent < 130) send_random_message();
    wait_drained();

    // Swap: sender mostly idle, receiver mostly ready.
    send_idle_pct = 86;
    recv_idle_pct = 25;
    while (items_sent < 250) send_random_message();
    wait_drained();

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (items_sent < 350) send_random_message();
    wait_drained();

    // Let any stray output show up before the verdict.
    repeat (300) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/shabs_pkg.sv
rtl/shabs_front.sv
rtl/shabs_fifo.sv
rtl/shabs_back.sv
rtl/sha256_byte_stream_hash.sv
rtl/shabs_checker.sv
test/sha256_digest_checker.sv
test/tb.sv
